[rtl/rcpld_pkg.sv]
// ----------------------------------------------------------------------------
// RC pulse LED drive package
// Shared widths, register indexes, sequencer states and the hue to RGB function.
// ----------------------------------------------------------------------------
package rcpld_pkg;

    localparam int CHANNELS      = 3;
    localparam int WIDTH_BITS    = 12;
    localparam int REG_W         = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int HUE_W         = 9;
    localparam int DIV_Q_W       = 9;
    localparam int DIV_D_W       = REG_W;
    localparam int DIV_N_W       = DIV_D_W + DIV_Q_W;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [REG_W-1:0] RST_MIN_VALID = 12'd800;
    localparam logic [REG_W-1:0] RST_MAX_VALID = 12'd2200;
    localparam logic [REG_W-1:0] RST_MAP_LOW   = 12'd1000;
    localparam logic [REG_W-1:0] RST_MAP_HIGH  = 12'd2000;
    localparam logic [REG_W-1:0] RST_ON_THRESH = 12'd1450;
    localparam logic [REG_W-1:0] RST_WIDTH     = 12'd1500;

    localparam logic [DIV_Q_W-1:0] FULL_BRIGHT = 9'd255;
    localparam logic [DIV_Q_W-1:0] FULL_HUE    = 9'd360;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESH = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_BRT,
        ST_DIV_BRT,
        ST_LOAD_HUE,
        ST_DIV_HUE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic t_rgb hue_to_rgb(input logic [HUE_W-1:0] hue);
        logic [2:0]  sector;
        logic [5:0]  rem;
        logic [HUE_W-1:0] base;
        logic [11:0] up_p;
        logic [11:0] dn_p;
        logic [7:0]  up;
        logic [7:0]  dn;
        t_rgb        res;
        if (hue >= 9'd300) begin
            sector = 3'd5; base = 9'd300;
        end else if (hue >= 9'd240) begin
            sector = 3'd4; base = 9'd240;
        end else if (hue >= 9'd180) begin
            sector = 3'd3; base = 9'd180;
        end else if (hue >= 9'd120) begin
            sector = 3'd2; base = 9'd120;
        end else if (hue >= 9'd60) begin
            sector = 3'd1; base = 9'd60;
        end else begin
            sector = 3'd0; base = 9'd0;
        end
        rem  = 6'(hue - base);
        up_p = 12'(rem) * 12'd17;
        dn_p = 12'(6'd60 - rem) * 12'd17;
        up   = up_p[9:2];
        dn   = dn_p[9:2];
        case (sector)
            3'd0: res = '{red: 8'd255, green: up,     blue: 8'd0};
            3'd1: res = '{red: dn,     green: 8'd255, blue: 8'd0};
            3'd2: res = '{red: 8'd0,   green: 8'd255, blue: up};
            3'd3: res = '{red: 8'd0,   green: dn,     blue: 8'd255};
            3'd4: res = '{red: up,     green: 8'd0,   blue: 8'd255};
            default: res = '{red: 8'd255, green: 8'd0, blue: dn};
        endcase
        return res;
    endfunction

endpackage

[rtl/rcpld_div.sv]
// ----------------------------------------------------------------------------
// RC pulse LED drive divider
// Restoring divider producing one quotient bit per cycle for a short quotient.
// ----------------------------------------------------------------------------
module rcpld_div #(
    parameter int N_W = rcpld_pkg::DIV_N_W,
    parameter int D_W = rcpld_pkg::DIV_D_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-D_W-1:0] o_quo
);
    localparam int Q_W   = N_W - D_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [Q_W-1:0]   r_lo;
    logic [Q_W-1:0]   r_quo;
    logic [D_W:0]     trial;
    logic             ge;

    assign trial = {r_rem, r_lo[Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(Q_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[N_W-1:Q_W];
            r_lo  <= i_num[Q_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
            r_lo  <= r_lo << 1;
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/rc_pulse_to_led_drive.sv]
// ----------------------------------------------------------------------------
// RC pulse to LED drive
// Measures three receiver pulse widths and maps them to LED drive levels.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word after the brightness and hue divisions.
// A new word is taken only when idle, after the last result has entered the output register.
// The two scalings run one after the other through one bit-serial divider.
// Synchronous reset restores register defaults, clears counters and levels,
// and sets every stored width to 1500.
module rc_pulse_to_led_drive #(
    parameter int WIDTH_BITS = rcpld_pkg::WIDTH_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // ch1_level, ch2_level, ch3_level, then zero fill
    input  logic [rcpld_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // brightness, led_on, red, green, blue, ch1_width, ch2_width, ch3_width,
    // then zero fill
    output logic [rcpld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rcpld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcpld_pkg::REG_W-1:0]       i_cfg_data
);
    import rcpld_pkg::*;

    t_state r_state, n_state;

    logic [REG_W-1:0] r_min, r_max, r_mlo, r_mhi, r_thr;

    logic [CHANNELS-1:0]   r_prev;
    logic [WIDTH_BITS-1:0] r_cnt   [CHANNELS];
    logic [REG_W-1:0]      r_width [CHANNELS];
    logic [WIDTH_BITS-1:0] n_cnt   [CHANNELS];
    logic [REG_W-1:0]      n_width [CHANNELS];

    logic [7:0]       r_bright;
    logic [HUE_W-1:0] r_hue;
    logic             r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic               in_acc;
    logic               div_start;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_quo;
    logic [REG_W-1:0]   sel_w;
    logic [DIV_Q_W-1:0] sel_full;
    logic [REG_W-1:0]   diff;
    logic [DIV_N_W-1:0] num;
    logic [REG_W-1:0]   den;
    logic               degen;
    logic               w_low;
    logic               w_high;
    logic               on;
    logic               out_free;
    t_rgb               rgb;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RST_MIN_VALID;
            r_max <= RST_MAX_VALID;
            r_mlo <= RST_MAP_LOW;
            r_mhi <= RST_MAP_HIGH;
            r_thr <= RST_ON_THRESH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_VALID: r_min <= i_cfg_data;
                CFG_MAX_VALID: r_max <= i_cfg_data;
                CFG_MAP_LOW:   r_mlo <= i_cfg_data;
                CFG_MAP_HIGH:  r_mhi <= i_cfg_data;
                CFG_ON_THRESH: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_cnt[c]   = r_cnt[c];
            n_width[c] = r_width[c];
            if (s_axis_tdata[c]) begin
                if (!r_prev[c]) begin
                    n_cnt[c] = WIDTH_BITS'(1);
                end else if (r_cnt[c] != {WIDTH_BITS{1'b1}}) begin
                    n_cnt[c] = r_cnt[c] + 1'b1;
                end
            end else if (r_prev[c]) begin
                if (r_cnt[c] >= WIDTH_BITS'(r_min) && r_cnt[c] <= WIDTH_BITS'(r_max)) begin
                    n_width[c] = r_cnt[c][REG_W-1:0];
                end
                n_cnt[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c]   <= '0;
                r_width[c] <= RST_WIDTH;
            end
        end else if (in_acc) begin
            r_prev <= s_axis_tdata[CHANNELS-1:0];
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c]   <= n_cnt[c];
                r_width[c] <= n_width[c];
            end
        end
    end

    assign sel_w    = (r_state == ST_LOAD_HUE || r_state == ST_DIV_HUE) ? r_width[2]
                                                                        : r_width[0];
    assign sel_full = (r_state == ST_LOAD_HUE) ? FULL_HUE : FULL_BRIGHT;
    assign diff     = sel_w - r_mlo;
    assign num      = DIV_N_W'(diff) * DIV_N_W'(sel_full);
    assign den      = r_mhi - r_mlo;
    assign degen    = r_mhi <= r_mlo;
    assign w_low    = sel_w <= r_mlo;
    assign w_high   = sel_w >= r_mhi;

    rcpld_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_LOAD_BRT;
            end
            ST_LOAD_BRT: begin
                div_start = 1'b1;
                n_state   = ST_DIV_BRT;
            end
            ST_DIV_BRT: begin
                if (div_done) n_state = ST_LOAD_HUE;
            end
            ST_LOAD_HUE: begin
                div_start = 1'b1;
                n_state   = ST_DIV_HUE;
            end
            ST_DIV_HUE: begin
                if (div_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV_BRT && div_done) begin
            if (degen || w_low) begin
                r_bright <= '0;
            end else if (w_high) begin
                r_bright <= FULL_BRIGHT[7:0];
            end else begin
                r_bright <= div_quo[7:0];
            end
        end
        if (r_state == ST_DIV_HUE && div_done) begin
            if (degen || w_low || w_high) begin
                r_hue <= '0;
            end else begin
                r_hue <= div_quo;
            end
        end
    end

    assign on  = r_width[1] > r_thr;
    assign rgb = hue_to_rgb(r_hue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out_data <= {3'b000, r_width[2], r_width[1], r_width[0],
                           on ? rgb.blue : 8'd0, on ? rgb.green : 8'd0,
                           on ? rgb.red : 8'd0, on, on ? r_bright : 8'd0};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
